FILE: design/multi_slot_alarm_countdown_top_defines.svh
//------------------------------------------------------------------------------
// multi_slot_alarm_countdown_top_defines.svh
// assertion macros used by the port checker
//------------------------------------------------------------------------------
`ifndef MULTI_SLOT_ALARM_COUNTDOWN_TOP_DEFINES_SVH
`define MULTI_SLOT_ALARM_COUNTDOWN_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MSAC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("msac check failed");

// next-cycle implication, disabled in reset
`define MSAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msac check failed");

`endif

FILE: design/msac_pkg.sv
//------------------------------------------------------------------------------
// msac_pkg
// shared types, constants and the set-value function of the alarm countdown
//------------------------------------------------------------------------------
package msac_pkg;

	localparam int SLOTS   = 4;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SEC_W   = 12;
	localparam int SEC_MAX = (1 << SEC_W) - 1;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SET    = 2'd1,
		OP_CANCEL = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_NOT_SET = 2'd2,
		ST_TICK    = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	typedef struct packed {
		logic             en;
		logic             active;
		logic [SEC_W-1:0] seconds;
	} bank_wr_t;

	// (10*mt+mo)*60 + 10*st+so, saturated to the count width
	function automatic logic [SEC_W-1:0] load_value(
		input logic [2:0] mt,
		input logic [3:0] mo,
		input logic [2:0] st,
		input logic [3:0] so
	);
		logic [6:0]  mins;
		logic [6:0]  secs;
		logic [13:0] total;
		mins  = 7'(mt) * 7'd10 + 7'(mo);
		secs  = 7'(st) * 7'd10 + 7'(so);
		total = 14'(mins) * 14'd60 + 14'(secs);
		if (total > 14'(SEC_MAX))
			return SEC_W'(SEC_MAX);
		return total[SEC_W-1:0];
	endfunction

endpackage

FILE: design/multi_slot_alarm_countdown_top.sv
//------------------------------------------------------------------------------
// multi_slot_alarm_countdown_top
// bank of alarm slots with set, cancel and one-second tick commands
//------------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// while one sequencer walks the slots, one slot per cycle, through a single
// decrement and zero-compare unit. A tick walks every slot, a set stops at
// the lowest free slot, and a cancel or an unused op takes a single step.
// The result shows for one cycle with done high in the cycle after the last
// step; busy is already low then, so the next item can be taken in that same
// cycle. The receiver cannot stall: a result not captured while done is high
// is gone.
module multi_slot_alarm_countdown_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] op,
	input  logic [2:0] minute_tens,
	input  logic [3:0] minute_ones,
	input  logic [2:0] second_tens,
	input  logic [3:0] second_ones,
	input  logic [1:0] cancel_slot,
	output logic       done,
	output logic [1:0] status,
	output logic [1:0] chosen_slot,
	output logic [3:0] fired_mask,
	output logic       any_fired,
	output logic [1:0] fired_slot
);

	localparam int SW = msac_pkg::SLOT_W;

	msac_pkg::state_t           state_q, state_d;
	msac_pkg::op_t              op_q;
	logic [SW-1:0]              idx_q;
	logic [msac_pkg::SEC_W-1:0] val_q;
	logic                       cancel_ok_q;
	logic [3:0]                 mask_q;
	logic                       any_q;
	logic [1:0]                 hi_q;

	logic                       done_q;
	msac_pkg::status_t          status_q;
	logic [1:0]                 chosen_q;
	logic [3:0]                 fmask_q;
	logic                       fany_q;
	logic [1:0]                 fslot_q;

	msac_pkg::bank_wr_t         wr;
	logic                       rd_active;
	logic [msac_pkg::SEC_W-1:0] rd_seconds;

	logic                       accept;
	logic                       last;
	logic                       finish;
	logic                       fire_now;
	msac_pkg::status_t          status_d;
	logic [1:0]                 chosen_d;
	logic [3:0]                 mask_n;
	logic                       any_n;
	logic [1:0]                 hi_n;

	msac_slot_bank u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.idx        (idx_q),
		.wr         (wr),
		.rd_active  (rd_active),
		.rd_seconds (rd_seconds)
	);

	assign busy   = (state_q != msac_pkg::S_IDLE);
	assign accept = start && !busy;
	assign last   = (idx_q == SW'(msac_pkg::SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= msac_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		wr         = '0;
		finish     = 1'b0;
		fire_now   = 1'b0;
		status_d   = msac_pkg::ST_DONE;
		chosen_d   = 2'd0;
		case (state_q)
			msac_pkg::S_IDLE: begin
				if (accept)
					state_d = msac_pkg::S_RUN;
			end
			msac_pkg::S_RUN: begin
				case (op_q)
					msac_pkg::OP_TICK: begin
						status_d = msac_pkg::ST_TICK;
						if (rd_active) begin
							wr.en = 1'b1;
							if (rd_seconds == '0) begin
								fire_now   = 1'b1;
								wr.active  = 1'b0;
								wr.seconds = '0;
							end else begin
								wr.active  = 1'b1;
								wr.seconds = rd_seconds - 1'b1;
							end
						end
						finish = last;
					end
					msac_pkg::OP_SET: begin
						if (!rd_active) begin
							wr.en      = 1'b1;
							wr.active  = 1'b1;
							wr.seconds = val_q;
							chosen_d   = 2'(idx_q);
							finish     = 1'b1;
						end else if (last) begin
							status_d = msac_pkg::ST_NO_FREE;
							finish   = 1'b1;
						end
					end
					msac_pkg::OP_CANCEL: begin
						if (cancel_ok_q && rd_active) begin
							wr.en      = 1'b1;
							wr.active  = 1'b0;
							wr.seconds = '0;
						end else begin
							status_d = msac_pkg::ST_NOT_SET;
						end
						finish = 1'b1;
					end
					default: begin
						finish = 1'b1;
					end
				endcase
				if (finish)
					state_d = msac_pkg::S_IDLE;
			end
			default: begin
				state_d = msac_pkg::S_IDLE;
			end
		endcase
	end

	assign mask_n = mask_q | (fire_now ? (4'd1 << idx_q) : 4'd0);
	assign any_n  = any_q | fire_now;
	assign hi_n   = fire_now ? 2'(idx_q) : hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= finish;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= msac_pkg::op_t'(op);
			val_q       <= msac_pkg::load_value(minute_tens, minute_ones,
				second_tens, second_ones);
			cancel_ok_q <= (32'(cancel_slot) < msac_pkg::SLOTS);
			idx_q       <= (msac_pkg::op_t'(op) == msac_pkg::OP_CANCEL) ?
				SW'(cancel_slot) : '0;
			mask_q      <= 4'd0;
			any_q       <= 1'b0;
			hi_q        <= 2'd0;
		end else if (state_q == msac_pkg::S_RUN) begin
			idx_q  <= idx_q + 1'b1;
			mask_q <= mask_n;
			any_q  <= any_n;
			hi_q   <= hi_n;
		end
		if (finish) begin
			status_q <= status_d;
			chosen_q <= chosen_d;
			fmask_q  <= mask_n;
			fany_q   <= any_n;
			fslot_q  <= hi_n;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign chosen_slot = chosen_q;
	assign fired_mask  = fmask_q;
	assign any_fired   = fany_q;
	assign fired_slot  = fslot_q;

endmodule

FILE: design/msac_slot_bank.sv
//------------------------------------------------------------------------------
// msac_slot_bank
// active flags and countdown registers of all slots, one slot per access
//------------------------------------------------------------------------------
module msac_slot_bank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [msac_pkg::SLOT_W-1:0]   idx,
	input  msac_pkg::bank_wr_t            wr,
	output logic                          rd_active,
	output logic [msac_pkg::SEC_W-1:0]    rd_seconds
);

	logic                       active_q  [msac_pkg::SLOTS];
	logic [msac_pkg::SEC_W-1:0] seconds_q [msac_pkg::SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < msac_pkg::SLOTS; i++) begin
				active_q[i]  <= 1'b0;
				seconds_q[i] <= '0;
			end
		end else if (wr.en) begin
			active_q[idx]  <= wr.active;
			seconds_q[idx] <= wr.seconds;
		end
	end

	assign rd_active  = active_q[idx];
	assign rd_seconds = seconds_q[idx];

endmodule

FILE: design/msac_checker.sv
//------------------------------------------------------------------------------
// msac_checker
// port-level checks of the alarm countdown top, bound to the top level
//------------------------------------------------------------------------------
`include "multi_slot_alarm_countdown_top_defines.svh"

module msac_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [3:0] fired_mask,
	input logic       any_fired,
	input logic [1:0] fired_slot
);

	`MSAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`MSAC_ASSERT_NOW(a_done_idle, done, !busy)
	`MSAC_ASSERT_NEXT(a_done_single, done, !done)
	`MSAC_ASSERT_NOW(a_cmd_no_fire, done && status != msac_pkg::ST_TICK, fired_mask == 4'd0 && !any_fired && fired_slot == 2'd0)

endmodule

bind multi_slot_alarm_countdown_top msac_port_checks u_msac_checker (.*);

FILE: tb/msac_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// msac_checker
// Watches the command and result ports of the alarm countdown bank. It keeps
// its own copy of the slot flags and counts, computes the result of every
// accepted item and compares each result strobe field by field with the
// oldest outstanding one.
//------------------------------------------------------------------------------
module msac_checker
	import msac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] op,
	input  logic [2:0] minute_tens,
	input  logic [3:0] minute_ones,
	input  logic [2:0] second_tens,
	input  logic [3:0] second_ones,
	input  logic [1:0] cancel_slot,
	input  logic       done,
	input  logic [1:0] status,
	input  logic [1:0] chosen_slot,
	input  logic [3:0] fired_mask,
	input  logic       any_fired,
	input  logic [1:0] fired_slot,
	output int         errors,
	output int         pending
);

	typedef struct packed {
		status_t    status;
		logic [1:0] chosen_slot;
		logic [3:0] fired_mask;
		logic       any_fired;
		logic [1:0] fired_slot;
	} alarm_result_t;

	logic             slot_on    [SLOTS];
	logic [SEC_W-1:0] slot_count [SLOTS];
	alarm_result_t    alarm_results[$];
	int               fail_count;

	function automatic alarm_result_t predict_alarm(
		input op_t        o,
		input logic [2:0] mt,
		input logic [3:0] mo,
		input logic [2:0] st,
		input logic [3:0] so,
		input logic [1:0] cs
	);
		alarm_result_t r;
		int            total;
		int            free_idx;
		r = '0;
		r.status = ST_DONE;
		case (o)
			OP_TICK: begin
				r.status = ST_TICK;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_on[i]) begin
						if (slot_count[i] == '0) begin
							slot_on[i] = 1'b0;
							r.any_fired = 1'b1;
							r.fired_slot = 2'(i);
							if (i < 4)
								r.fired_mask[i] = 1'b1;
						end else begin
							slot_count[i] = slot_count[i] - 1'b1;
						end
					end
				end
			end
			OP_SET: begin
				total = (int'(mt) * 10 + int'(mo)) * 60 + int'(st) * 10 + int'(so);
				if (total > SEC_MAX)
					total = SEC_MAX;
				free_idx = -1;
				for (int i = SLOTS - 1; i >= 0; i--) begin
					if (!slot_on[i])
						free_idx = i;
				end
				if (free_idx < 0) begin
					r.status = ST_NO_FREE;
				end else begin
					slot_on[free_idx] = 1'b1;
					slot_count[free_idx] = SEC_W'(total);
					r.chosen_slot = 2'(free_idx);
				end
			end
			OP_CANCEL: begin
				if (int'(cs) < SLOTS && slot_on[cs]) begin
					slot_on[cs] = 1'b0;
					slot_count[cs] = '0;
				end else begin
					r.status = ST_NOT_SET;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alarm_result_t due;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_on[i] = 1'b0;
				slot_count[i] = '0;
			end
			alarm_results.delete();
			fail_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (alarm_results.size() == 0) begin
					$error("result strobe with no item outstanding");
					fail_count++;
				end else begin
					due = alarm_results.pop_front();
					check_field("status", 4'(due.status), 4'(status));
					check_field("chosen_slot", 4'(due.chosen_slot), 4'(chosen_slot));
					check_field("fired_mask", due.fired_mask, fired_mask);
					check_field("any_fired", 4'(due.any_fired), 4'(any_fired));
					check_field("fired_slot", 4'(due.fired_slot), 4'(fired_slot));
				end
			end
			if (start && !busy)
				alarm_results.push_back(predict_alarm(op_t'(op), minute_tens, minute_ones,
					second_tens, second_ones, cancel_slot));
			errors <= fail_count;
			pending <= alarm_results.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench
// Drives set, cancel and tick commands into the alarm countdown bank: a
// directed opening that fills, fires and cancels slots, then random command
// streams in phases of varying sender idling. Checking is done by the
// checker instance; this module gives the verdict.
//------------------------------------------------------------------------------
module testbench;
	import msac_pkg::*;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       start       = 1'b0;
	logic [1:0] op          = '0;
	logic [2:0] minute_tens = '0;
	logic [3:0] minute_ones = '0;
	logic [2:0] second_tens = '0;
	logic [3:0] second_ones = '0;
	logic [1:0] cancel_slot = '0;
	logic       busy;
	logic       done;
	logic [1:0] status;
	logic [1:0] chosen_slot;
	logic [3:0] fired_mask;
	logic       any_fired;
	logic [1:0] fired_slot;
	int         errors;
	int         pending;
	int         quiet_cycles = 0;
	int         idle_pct[4]  = '{0, 48, 29, 0};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_slot_alarm_countdown_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.minute_tens(minute_tens), .minute_ones(minute_ones),
		.second_tens(second_tens), .second_ones(second_ones),
		.cancel_slot(cancel_slot), .done(done), .status(status),
		.chosen_slot(chosen_slot), .fired_mask(fired_mask),
		.any_fired(any_fired), .fired_slot(fired_slot)
	);

	msac_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.minute_tens(minute_tens), .minute_ones(minute_ones),
		.second_tens(second_tens), .second_ones(second_ones),
		.cancel_slot(cancel_slot), .done(done), .status(status),
		.chosen_slot(chosen_slot), .fired_mask(fired_mask),
		.any_fired(any_fired), .fired_slot(fired_slot),
		.errors(errors), .pending(pending)
	);

	// returns at the edge where the item is taken
	task automatic send_item(
		input op_t        o,
		input logic [2:0] mt,
		input logic [3:0] mo,
		input logic [2:0] st,
		input logic [3:0] so,
		input logic [1:0] cs
	);
		start       <= 1'b1;
		op          <= o;
		minute_tens <= mt;
		minute_ones <= mo;
		second_tens <= st;
		second_ones <= so;
		cancel_slot <= cs;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		op_t        o;
		int         pick;
		logic [2:0] mt;
		logic [3:0] mo;
		logic [2:0] st;
		logic [3:0] so;
		mt = 3'($urandom);
		mo = 4'($urandom);
		st = 3'($urandom);
		so = 4'($urandom);
		pick = $urandom_range(99);
		if (pick < 45)
			o = OP_TICK;
		else if (pick < 72)
			o = OP_SET;
		else if (pick < 95)
			o = OP_CANCEL;
		else
			o = OP_NONE;
		if (o == OP_SET) begin
			pick = $urandom_range(99);
			// mostly short counts so slots fire often
			if (pick < 95) begin
				st = 3'($urandom_range(5));
				so = 4'($urandom_range(9));
				mt = 3'($urandom_range(5));
				mo = 4'($urandom_range(9));
			end
			if (pick < 85) begin
				mt = '0;
				mo = '0;
			end
			if (pick < 65)
				st = '0;
		end
		send_item(o, mt, mo, st, so, 2'($urandom));
	endtask

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == 2000) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, unused op, cancels, fill, overflow, fires
		send_item(OP_TICK, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_NONE, 3'd7, 4'd15, 3'd7, 4'd15, 2'd3);
		send_item(OP_CANCEL, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_SET, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_SET, 3'd0, 4'd0, 3'd0, 4'd1, 2'd0);
		send_item(OP_SET, 3'd7, 4'd15, 3'd7, 4'd15, 2'd0);
		send_item(OP_SET, 3'd5, 4'd9, 3'd5, 4'd9, 2'd0);
		send_item(OP_SET, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_CANCEL, 3'd0, 4'd0, 3'd0, 4'd0, 2'd3);
		send_item(OP_CANCEL, 3'd0, 4'd0, 3'd0, 4'd0, 2'd3);
		send_item(OP_TICK, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_TICK, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_SET, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_SET, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_SET, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_TICK, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_SET, 3'd1, 4'd2, 3'd3, 4'd4, 2'd0);
		send_item(OP_CANCEL, 3'd0, 4'd0, 3'd0, 4'd0, 2'd2);
		send_item(OP_CANCEL, 3'd0, 4'd0, 3'd0, 4'd0, 2'd1);
		send_item(OP_CANCEL, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		send_item(OP_TICK, 3'd0, 4'd0, 3'd0, 4'd0, 2'd0);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < 333; n++) begin
				if ($urandom_range(99) < idle_pct[ph]) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end else if ($urandom_range(199) == 0) begin
					wait_drained();
				end
				send_random();
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
